// File: rtl/core/g2o_pkg.sv
package g2o_pkg;

    // font geometry
    localparam int FONT_GLYPHS = 96;
    localparam int FONT_AW     = 7;
    localparam int GLYPH_W     = 40;

    typedef logic [GLYPH_W-1:0] t_glyph;
    typedef logic [FONT_AW-1:0] t_font_addr;

    // byte sequence per character: 6 command bytes then 24 data bytes
    localparam logic [4:0] CMD_BYTES = 5'd6;
    localparam logic [4:0] LAST_BEAT = 5'd29;

    // display controller commands
    localparam logic [7:0] CMD_SET_COL = 8'h15;
    localparam logic [7:0] CMD_SET_ROW = 8'h75;

    // register indexes
    localparam logic REG_ORIENT = 1'b0;
    localparam logic REG_COLOR  = 1'b1;

    // register reset values
    localparam logic       ORIENT_RST = 1'b1;
    localparam logic [7:0] COLOR_RST  = 8'h0F;

    // portrait text grid limits
    localparam logic [7:0] PORT_MAX_COL = 8'd11;
    localparam logic [7:0] PORT_MAX_ROW = 8'd12;

    localparam logic [3:0] FULL_LEVEL = 4'hF;

    // character code to font row; codes outside 0x20..0x7F map to space (row 0)
    function automatic t_font_addr code_to_addr(input logic [7:0] code);
        t_font_addr a;
        a = '0;
        if (!code[7] && (code[6:5] != 2'b00)) begin
            a = {code[6:5] - 2'd1, code[4:0]};
        end
        return a;
    endfunction

    // one font column byte; columns 5..7 read as blank
    function automatic logic [7:0] glyph_col(input t_glyph g, input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = g[39:32];
            3'd1:    c = g[31:24];
            3'd2:    c = g[23:16];
            3'd3:    c = g[15:8];
            3'd4:    c = g[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // 5x7 font, leftmost column in the top byte
    function automatic t_glyph font_row(input t_font_addr a);
        t_glyph g;
        case (a)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00005f0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147f147f14;
            7'd4:  g = 40'h242a7f2a12;
            7'd5:  g = 40'hc4c8102646;
            7'd6:  g = 40'h3649552250;
            7'd7:  g = 40'h0205020000;
            7'd8:  g = 40'h001c224100;
            7'd9:  g = 40'h0041221c00;
            7'd10: g = 40'h14083e0814;
            7'd11: g = 40'h08083e0808;
            7'd12: g = 40'h0000503000;
            7'd13: g = 40'h1010101010;
            7'd14: g = 40'h0060600000;
            7'd15: g = 40'h2010080402;
            7'd16: g = 40'h3e5149453e;
            7'd17: g = 40'h00427f4000;
            7'd18: g = 40'h4261514946;
            7'd19: g = 40'h2241494936;
            7'd20: g = 40'h1814127f10;
            7'd21: g = 40'h2745454539;
            7'd22: g = 40'h3c4a494930;
            7'd23: g = 40'h0171090503;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h064949291e;
            7'd26: g = 40'h0036360000;
            7'd27: g = 40'h0056360000;
            7'd28: g = 40'h0814224100;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h0041221408;
            7'd31: g = 40'h0201510906;
            7'd32: g = 40'h324959513e;
            7'd33: g = 40'h7e1111117e;
            7'd34: g = 40'h7f49494936;
            7'd35: g = 40'h3e41414122;
            7'd36: g = 40'h7f4141221c;
            7'd37: g = 40'h7f49494941;
            7'd38: g = 40'h7f09090901;
            7'd39: g = 40'h3e4149497a;
            7'd40: g = 40'h7f0808087f;
            7'd41: g = 40'h00417f4100;
            7'd42: g = 40'h2040413f01;
            7'd43: g = 40'h7f08142241;
            7'd44: g = 40'h7f40404040;
            7'd45: g = 40'h7f020c027f;
            7'd46: g = 40'h7f0408107f;
            7'd47: g = 40'h3e4141413e;
            7'd48: g = 40'h7f09090906;
            7'd49: g = 40'h3e4151215e;
            7'd50: g = 40'h7f09192946;
            7'd51: g = 40'h4649494931;
            7'd52: g = 40'h01017f0101;
            7'd53: g = 40'h3f4040403f;
            7'd54: g = 40'h1f2040201f;
            7'd55: g = 40'h3f4038403f;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807;
            7'd58: g = 40'h6151494543;
            7'd59: g = 40'h007f414100;
            7'd60: g = 40'h552a552a55;
            7'd61: g = 40'h0041417f00;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040;
            7'd64: g = 40'h0001020400;
            7'd65: g = 40'h2054545478;
            7'd66: g = 40'h7f48444438;
            7'd67: g = 40'h3844444420;
            7'd68: g = 40'h384444487f;
            7'd69: g = 40'h3854545418;
            7'd70: g = 40'h087e090102;
            7'd71: g = 40'h0c5252523e;
            7'd72: g = 40'h7f08040478;
            7'd73: g = 40'h00447d4000;
            7'd74: g = 40'h2040443d00;
            7'd75: g = 40'h7f10284400;
            7'd76: g = 40'h00417f4000;
            7'd77: g = 40'h7c04180478;
            7'd78: g = 40'h7c08040478;
            7'd79: g = 40'h3844444438;
            7'd80: g = 40'h7c14141408;
            7'd81: g = 40'h081414187c;
            7'd82: g = 40'h7c08040408;
            7'd83: g = 40'h4854545420;
            7'd84: g = 40'h043f444020;
            7'd85: g = 40'h3c4040207c;
            7'd86: g = 40'h1c2040201c;
            7'd87: g = 40'h3c4030403c;
            7'd88: g = 40'h4428102844;
            7'd89: g = 40'h0c5050503c;
            7'd90: g = 40'h4464544c44;
            7'd91: g = 40'h0008364100;
            7'd92: g = 40'h00007f0000;
            7'd93: g = 40'h0041360800;
            7'd94: g = 40'h08082a1c08;
            7'd95: g = 40'h081c2a0808;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

// File: rtl/core/g2o_ram.sv
module g2o_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                      i_wdata,
    input  logic                              i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                      o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/glyph_to_gray_oled_bytes_top.sv
// Character generator for a 4-bit grayscale OLED controller. Each request carries a
// character code and a text-cell position; the block answers with 30 bytes, one per
// cycle when the sink is ready: column window command (0x15, start, end), row window
// command (0x75, start, end), then 24 glyph data bytes with two 4-bit pixels each
// (high nibble is the left pixel). o_last marks the final byte. Codes outside
// 0x20..0x7F draw as a space. In portrait mode (reset default) cells beyond column 11
// or row 12 are dropped with no output; the low nibble of the color register sets the
// gray level and color bit 7 inverts the glyph. Landscape mode always draws full white
// and lets the window addresses wrap at 8 bits. After reset the 96-entry font memory is
// loaded, during which no request is taken (register writes are). After that the next
// request is taken while the current character is still streaming, so characters
// follow with no gap. A dropped portrait request is discarded in the cycle after it is
// taken and does not hold up the next request. Register writes are only allowed while
// the block is idle.
module glyph_to_gray_oled_bytes_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_column_pos,
    input  logic [7:0] i_row_pos,
    // byte channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_command,
    output logic       o_last
);

    // configuration registers
    logic       r_orient;
    logic [7:0] r_color;

    // font load sweep
    logic                     r_fill_done;
    g2o_pkg::t_font_addr      r_fill_addr;

    // pending request: glyph waits on the font memory output
    logic       r_pd_v;
    logic [7:0] r_pd_col;
    logic [7:0] r_pd_row;
    logic [7:0] n_pd_col;
    logic [7:0] n_pd_row;
    logic       n_pd_v;

    // active character being streamed
    logic             r_job_v;
    logic [4:0]       r_cnt;
    logic [2:0]       r_y;
    logic [1:0]       r_sub;
    g2o_pkg::t_glyph  r_glyph;
    logic [7:0]       r_cs;
    logic [7:0]       r_ce;
    logic [7:0]       r_rs;
    logic [7:0]       r_re;
    logic             n_job_v;
    logic [4:0]       n_cnt;
    logic [2:0]       n_y;
    logic [1:0]       n_sub;
    g2o_pkg::t_glyph  n_glyph;
    logic [7:0]       n_cs;
    logic [7:0]       n_ce;
    logic [7:0]       n_rs;
    logic [7:0]       n_re;

    g2o_pkg::t_glyph  font_rdata;
    logic             in_acc;
    logic             pd_reject;
    logic             job_free;
    logic             pd_take;
    logic             job_load;
    logic             beat;
    logic [1:0]       sub_max;

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= g2o_pkg::ORIENT_RST;
            r_color  <= g2o_pkg::COLOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                g2o_pkg::REG_ORIENT: r_orient <= i_cfg_wdata[0];
                g2o_pkg::REG_COLOR:  r_color  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // font memory: loaded from the package table after reset, then
    // read once per accepted request
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_done <= 1'b0;
            r_fill_addr <= '0;
        end else if (!r_fill_done) begin
            if (r_fill_addr == g2o_pkg::FONT_AW'(g2o_pkg::FONT_GLYPHS - 1)) begin
                r_fill_done <= 1'b1;
            end else begin
                r_fill_addr <= r_fill_addr + g2o_pkg::t_font_addr'(1);
            end
        end
    end

    g2o_ram #(
        .W (g2o_pkg::GLYPH_W),
        .D (g2o_pkg::FONT_GLYPHS)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (!r_fill_done),
        .i_waddr (r_fill_addr),
        .i_wdata (g2o_pkg::font_row(r_fill_addr)),
        .i_re    (in_acc),
        .i_raddr (g2o_pkg::code_to_addr(i_char_code)),
        .o_rdata (font_rdata)
    );

    // ---------------------------------------------------------------
    // request flow: pending slot hands over to the streamer when it is idle or
    // finishes its last byte, so characters run back to back
    // ---------------------------------------------------------------
    assign pd_reject  = r_orient && ((r_pd_col > g2o_pkg::PORT_MAX_COL) ||
                                     (r_pd_row > g2o_pkg::PORT_MAX_ROW));
    assign beat       = r_job_v && i_out_ready;
    assign job_free   = !r_job_v || (i_out_ready && (r_cnt == g2o_pkg::LAST_BEAT));
    assign pd_take    = r_pd_v && (pd_reject || job_free);
    assign job_load   = r_pd_v && !pd_reject && job_free;
    assign o_in_ready = r_fill_done && (!r_pd_v || pd_take);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_pd_v   = r_pd_v;
        n_pd_col = r_pd_col;
        n_pd_row = r_pd_row;
        if (pd_take) begin
            n_pd_v = 1'b0;
        end
        if (in_acc) begin
            n_pd_v   = 1'b1;
            n_pd_col = i_column_pos;
            n_pd_row = i_row_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pd_v <= 1'b0;
        end else begin
            r_pd_v <= n_pd_v;
        end
        r_pd_col <= n_pd_col;
        r_pd_row <= n_pd_row;
    end

    // ---------------------------------------------------------------
    // streamer: window bytes are worked out at load time, the data
    // bytes are picked from the glyph by row (r_y) and pair (r_sub)
    // ---------------------------------------------------------------
    assign sub_max = r_orient ? 2'd3 : 2'd2;

    always_comb begin
        n_job_v = r_job_v;
        n_cnt   = r_cnt;
        n_y     = r_y;
        n_sub   = r_sub;
        n_glyph = r_glyph;
        n_cs    = r_cs;
        n_ce    = r_ce;
        n_rs    = r_rs;
        n_re    = r_re;
        if (job_load) begin
            n_job_v = 1'b1;
            n_cnt   = '0;
            n_y     = '0;
            n_sub   = '0;
            n_glyph = font_rdata;
            if (r_orient) begin
                // portrait: columns mirrored, 4 columns x 6 rows per cell
                n_cs = 8'd54 - {r_pd_col[5:0], 2'b00};
                n_ce = n_cs + 8'd3;
                n_rs = {r_pd_row[6:0], 1'b0} + {r_pd_row[5:0], 2'b00};
                n_re = n_rs + 8'd5;
            end else begin
                // landscape: 3 columns x 8 rows per cell
                n_cs = 8'd7 + r_pd_col + {r_pd_col[6:0], 1'b0};
                n_ce = n_cs + 8'd2;
                n_rs = {r_pd_row[4:0], 3'b000};
                n_re = n_rs + 8'd7;
            end
        end else if (beat) begin
            if (r_cnt == g2o_pkg::LAST_BEAT) begin
                n_job_v = 1'b0;
            end else begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt >= g2o_pkg::CMD_BYTES) begin
                    if (r_sub == sub_max) begin
                        n_sub = '0;
                        n_y   = r_y + 3'd1;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
        end else begin
            r_job_v <= n_job_v;
        end
        r_cnt   <= n_cnt;
        r_y     <= n_y;
        r_sub   <= n_sub;
        r_glyph <= n_glyph;
        r_cs    <= n_cs;
        r_ce    <= n_ce;
        r_rs    <= n_rs;
        r_re    <= n_re;
    end

    // ---------------------------------------------------------------
    // output byte
    // ---------------------------------------------------------------
    logic [7:0] pix_byte;
    logic [7:0] p_row;
    logic [7:0] l_left;
    logic [7:0] l_right;
    logic       lb;
    logic       rb;
    logic [3:0] level;

    always_comb begin
        // portrait: font column r_y is one display row, inverted on request
        p_row   = g2o_pkg::glyph_col(r_glyph, r_y) ^ {8{r_color[7]}};
        // landscape: pairs of font columns sampled at bit r_y
        l_left  = g2o_pkg::glyph_col(r_glyph, {r_sub, 1'b0});
        l_right = g2o_pkg::glyph_col(r_glyph, {r_sub, 1'b1});
        if (r_orient) begin
            lb    = p_row[3'd7 - {r_sub, 1'b0}];
            rb    = p_row[3'd6 - {r_sub, 1'b0}];
            level = r_color[3:0];
        end else begin
            lb    = l_left[r_y];
            // spacing column on the third byte
            rb    = (r_sub != 2'd2) && l_right[r_y];
            level = g2o_pkg::FULL_LEVEL;
        end
        pix_byte = {lb ? level : 4'h0, rb ? level : 4'h0};
    end

    always_comb begin
        case (r_cnt)
            5'd0:    o_out_byte = g2o_pkg::CMD_SET_COL;
            5'd1:    o_out_byte = r_cs;
            5'd2:    o_out_byte = r_ce;
            5'd3:    o_out_byte = g2o_pkg::CMD_SET_ROW;
            5'd4:    o_out_byte = r_rs;
            5'd5:    o_out_byte = r_re;
            default: o_out_byte = pix_byte;
        endcase
    end

    assign o_out_valid  = r_job_v;
    assign o_is_command = (r_cnt < g2o_pkg::CMD_BYTES);
    assign o_last       = (r_cnt == g2o_pkg::LAST_BEAT);

`ifndef SYNTHESIS
    // no request reaches the font memory before it is loaded
    a_acc_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> r_fill_done)
        else $error("request accepted during font load");

    // a waiting request keeps its position until the streamer takes it or it is dropped
    a_pd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pd_v && !pd_take |=> r_pd_v && $stable(r_pd_col) && $stable(r_pd_row))
        else $error("pending request lost");

    // after the final byte either the stream stops or a new one starts at byte 0
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last |=> !o_out_valid || (r_cnt == 5'd0))
        else $error("character stream did not restart cleanly");

    // portrait rows never run past the spacing column
    a_port_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_v && r_orient |-> (r_y <= 3'd5) && (r_sub <= 2'd3))
        else $error("portrait row index out of range");
`endif

endmodule
